// File: rtl/osc_pkg.sv
// Package for the odd-subset constraint generator.
// Holds widths, register map, controller state type and the
// command/status structs; no dependencies.
`default_nettype none

package osc_pkg;

    localparam int MAX_DEGREE_DEF = 6;
    localparam int MASK_BITS      = 6;
    localparam int POS_W          = 3;
    localparam int DEG_W          = 3;
    localparam int ROW_W          = 10;
    localparam int BOUND_W        = 3;
    localparam int CNT_W          = 4;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [DEG_W-1:0] ROW_DEGREE_RESET = 3'd6;

    // Register index as seen at paddr[2].
    localparam logic REG_ROW_DEGREE = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/osc_if.sv
// Handshake channel interfaces for the odd-subset constraint generator.
// Depends on osc_pkg for the field widths.
`default_nettype none

interface osc_in_if;
    logic                          valid;
    logic                          ready;
    logic [osc_pkg::ROW_W-1:0]     row_index;

    modport source (output valid, output row_index, input ready);
    modport sink   (input valid, input row_index, output ready);
endinterface

interface osc_out_if;
    logic                          valid;
    logic                          ready;
    logic [osc_pkg::ROW_W-1:0]     row_tag;
    logic [osc_pkg::MASK_BITS-1:0] sign_mask;
    logic [osc_pkg::BOUND_W-1:0]   bound;
    logic                          last;

    modport source (output valid, output row_tag, output sign_mask, output bound,
                    output last, input ready);
    modport sink   (input valid, input row_tag, input sign_mask, input bound,
                    input last, output ready);
endinterface

`default_nettype wire

// File: rtl/odd_subset_constraint_generator.sv
// Top level of the odd-subset constraint generator: configuration register,
// controller and datapath. Depends on osc_pkg, osc_if, osc_ctrl, osc_datapath.
//
//   channel   direction  transaction carries
//   i_in      sink       row_index
//   o_out     source     row_tag, sign_mask, bound, last
//   APB       slave      row_degree at byte address 0
//
// A row with effective degree d yields 2^(d-1) constraints, one per cycle
// while the sink keeps ready high. The rate is set by the single combination
// stepper, which advances once per emitted constraint. The next row is taken
// as soon as the last constraint of the current row has entered the output
// register. A stalled sink holds the stepper. Reset is synchronous and clears
// control state and row_degree to 6.
`default_nettype none

module odd_subset_constraint_generator #(
    parameter int MAX_DEGREE = osc_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    osc_in_if.sink                             i_in,
    osc_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [osc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [osc_pkg::PDATA_W-1:0]   pwdata,
    output logic [osc_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [osc_pkg::DEG_W-1:0] r_row_degree;
    logic                      reg_sel;
    osc_pkg::t_cmd             cmd;
    osc_pkg::t_status          status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == osc_pkg::REG_ROW_DEGREE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_degree <= osc_pkg::ROW_DEGREE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_row_degree <= pwdata[osc_pkg::DEG_W-1:0];
        end
    end

    assign prdata = reg_sel ? osc_pkg::PDATA_W'(r_row_degree) : '0;

    osc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    osc_datapath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_row_index  (i_in.row_index),
        .i_row_degree (r_row_degree),
        .o_status     (status),
        .o_row_tag    (o_out.row_tag),
        .o_sign_mask  (o_out.sign_mask),
        .o_bound      (o_out.bound),
        .o_last       (o_out.last)
    );

endmodule

`default_nettype wire

// File: rtl/osc_ctrl.sv
// Controller for the odd-subset constraint generator: row acceptance,
// emission pacing and the output valid flag. Depends on osc_pkg.
`default_nettype none

module osc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire osc_pkg::t_status i_status,
    output osc_pkg::t_cmd        o_cmd
);

    osc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= osc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            osc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = osc_pkg::ST_GEN;
                end
            end
            osc_pkg::ST_GEN: begin
                // A new constraint enters the output register when it is empty
                // or is being drained in this cycle.
                o_cmd.emit = !r_out_valid || i_out_ready;
                if (o_cmd.emit && i_status.last) begin
                    n_state = osc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = osc_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/osc_datapath.sv
// Datapath for the odd-subset constraint generator: current combination,
// lexicographic successor logic and the output register. Depends on osc_pkg.
`default_nettype none

module osc_datapath #(
    parameter int MAX_DEGREE = osc_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                          i_clk,
    input  wire osc_pkg::t_cmd                 i_cmd,
    input  wire logic [osc_pkg::ROW_W-1:0]     i_row_index,
    input  wire logic [osc_pkg::DEG_W-1:0]     i_row_degree,
    output osc_pkg::t_status                   o_status,
    output logic [osc_pkg::ROW_W-1:0]          o_row_tag,
    output logic [osc_pkg::MASK_BITS-1:0]      o_sign_mask,
    output logic [osc_pkg::BOUND_W-1:0]        o_bound,
    output logic                               o_last
);

    localparam int DEG_MAX = (MAX_DEGREE < osc_pkg::MASK_BITS) ?
                             MAX_DEGREE : osc_pkg::MASK_BITS;
    localparam int PW = osc_pkg::POS_W;
    localparam int CW = osc_pkg::CNT_W;

    logic [PW-1:0]                    r_pos [MAX_DEGREE];
    logic [PW-1:0]                    n_pos [MAX_DEGREE];
    logic [osc_pkg::DEG_W-1:0]        r_size, n_size;
    logic [osc_pkg::ROW_W-1:0]        r_held_row;
    logic [osc_pkg::ROW_W-1:0]        r_row_tag;
    logic [osc_pkg::MASK_BITS-1:0]    r_sign_mask;
    logic [osc_pkg::BOUND_W-1:0]      r_bound;
    logic                             r_last;

    logic [CW-1:0]                    eff_deg;
    logic [CW-1:0]                    size_w;
    logic [osc_pkg::MASK_BITS-1:0]    cur_mask;
    logic                             found;
    logic [CW-1:0]                    pivot;
    logic [PW-1:0]                    piv_pos;
    logic                             last_comb;

    // Degree zero counts as one; large degrees saturate.
    always_comb begin
        if (i_row_degree == '0) begin
            eff_deg = CW'(1);
        end else if ({1'b0, i_row_degree} > CW'(DEG_MAX)) begin
            eff_deg = CW'(DEG_MAX);
        end else begin
            eff_deg = {1'b0, i_row_degree};
        end
    end

    assign size_w = {1'b0, r_size};

    always_comb begin
        cur_mask = '0;
        found    = 1'b0;
        pivot    = '0;
        piv_pos  = '0;
        for (int i = 0; i < MAX_DEGREE; i++) begin
            if (CW'(i) < size_w) begin
                cur_mask = cur_mask | (osc_pkg::MASK_BITS'(1) << r_pos[i]);
                // Rightmost position that can still move up is the pivot.
                if ({1'b0, r_pos[i]} < eff_deg - size_w + CW'(i)) begin
                    found   = 1'b1;
                    pivot   = CW'(i);
                    piv_pos = r_pos[i];
                end
            end
        end
        last_comb = !found && (size_w + CW'(2) > eff_deg);
    end

    assign o_status.last = last_comb;

    always_comb begin
        n_size = r_size;
        for (int j = 0; j < MAX_DEGREE; j++) begin
            n_pos[j] = r_pos[j];
        end
        if (i_cmd.load) begin
            n_size = osc_pkg::DEG_W'(1);
            for (int j = 0; j < MAX_DEGREE; j++) begin
                n_pos[j] = PW'(j);
            end
        end else if (i_cmd.emit) begin
            if (found) begin
                for (int j = 0; j < MAX_DEGREE; j++) begin
                    if (CW'(j) >= pivot) begin
                        n_pos[j] = PW'({1'b0, piv_pos} + CW'(j) - pivot + CW'(1));
                    end
                end
            end else begin
                // Move on to the next odd subset size, starting from the lowest positions.
                n_size = r_size + osc_pkg::DEG_W'(2);
                for (int j = 0; j < MAX_DEGREE; j++) begin
                    n_pos[j] = PW'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        for (int j = 0; j < MAX_DEGREE; j++) begin
            r_pos[j] <= n_pos[j];
        end
        if (i_cmd.load) begin
            r_held_row <= i_row_index;
        end
        if (i_cmd.emit) begin
            r_row_tag   <= r_held_row;
            r_sign_mask <= cur_mask;
            r_bound     <= r_size - osc_pkg::BOUND_W'(1);
            r_last      <= last_comb;
        end
    end

    assign o_row_tag   = r_row_tag;
    assign o_sign_mask = r_sign_mask;
    assign o_bound     = r_bound;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: rtl/osc_checker.sv
// Port-level checker for the odd-subset constraint generator, bound to the
// top level. Depends on osc_pkg for field widths.
`default_nettype none

module osc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [osc_pkg::MASK_BITS-1:0] i_sign_mask,
    input wire logic [osc_pkg::BOUND_W-1:0]   i_bound
);

    // Once a row is taken, no other row is taken before it has been expanded.
    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second row accepted while a row is being expanded");

    // Every subset is odd, so the bound is even.
    a_even_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bound[0] == 1'b0))
        else $error("odd bound on a constraint");

    // The mask has exactly bound + 1 members.
    a_mask_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($countones(i_sign_mask) == int'(i_bound) + 1))
        else $error("sign mask size disagrees with bound");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped while stalled");

endmodule

bind odd_subset_constraint_generator osc_checker u_osc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sign_mask (o_out.sign_mask),
    .i_bound     (o_out.bound)
);

`default_nettype wire

// File: tb/tb.sv
// Testbench for odd_subset_constraint_generator: drives row tags, programs row_degree
// over APB and checks every emitted constraint against an in-bench expansion.
// Depends on osc_pkg, osc_if and the RTL top level.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ROWS  = 200;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [osc_pkg::PADDR_W-1:0] ADDR_ROW_DEGREE =
        {osc_pkg::REG_ROW_DEGREE, 2'b00};
    localparam logic [osc_pkg::PADDR_W-1:0] ADDR_UNMAPPED   =
        {~osc_pkg::REG_ROW_DEGREE, 2'b00};

    typedef struct packed {
        logic [osc_pkg::ROW_W-1:0]     row_tag;
        logic [osc_pkg::MASK_BITS-1:0] sign_mask;
        logic [osc_pkg::BOUND_W-1:0]   bound;
        logic                          last;
    } t_ineq;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [osc_pkg::PADDR_W-1:0] paddr;
    logic [osc_pkg::PDATA_W-1:0] pwdata;
    logic [osc_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    osc_in_if  in_ch ();
    osc_out_if out_ch ();

    odd_subset_constraint_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [osc_pkg::ROW_W-1:0] pending_rows [$];
    t_ineq                     expected_ineqs [$];
    logic [osc_pkg::DEG_W-1:0] shadow_degree = osc_pkg::ROW_DEGREE_RESET;
    logic                      quiet_phase   = 1'b0;
    logic                      in_fire       = 1'b0;
    int                        in_gap        = 0;
    int                        out_stall     = 0;
    int                        cycle_count   = 0;
    int                        errors        = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none at all in a quiet phase.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (quiet_phase || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Appends the constraints of one row: odd subset sizes in rising order, and within
    // a size the sorted position lists in lexicographic order.
    function automatic void expand_row(input logic [osc_pkg::ROW_W-1:0] row);
        int d;
        int k;
        int i;
        int j;
        int pivot;
        int pos [osc_pkg::MAX_DEGREE_DEF];
        logic [osc_pkg::MASK_BITS-1:0] mask;
        t_ineq ineq;
        d = int'(shadow_degree);
        if (d < 1) d = 1;
        if (d > osc_pkg::MAX_DEGREE_DEF) d = osc_pkg::MAX_DEGREE_DEF;
        if (d > osc_pkg::MASK_BITS) d = osc_pkg::MASK_BITS;
        for (k = 1; k <= d; k += 2) begin
            for (i = 0; i < k; i++) pos[i] = i;
            pivot = 0;
            while (pivot >= 0) begin
                mask = '0;
                for (i = 0; i < k; i++) mask[pos[i]] = 1'b1;
                ineq.row_tag   = row;
                ineq.sign_mask = mask;
                ineq.bound     = osc_pkg::BOUND_W'(k - 1);
                ineq.last      = 1'b0;
                expected_ineqs.push_back(ineq);
                // The rightmost position that can still move is bumped and the
                // ones after it are packed right behind it.
                pivot = -1;
                for (i = 0; i < k; i++) begin
                    if (pos[i] < d - k + i) pivot = i;
                end
                if (pivot >= 0) begin
                    pos[pivot]++;
                    for (j = pivot + 1; j < k; j++) pos[j] = pos[j - 1] + 1;
                end
            end
        end
        ineq = expected_ineqs.pop_back();
        ineq.last = 1'b1;
        expected_ineqs.push_back(ineq);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Row driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_rows.size() > 0) begin
                in_ch.row_index <= pending_rows.pop_front();
                in_ch.valid     <= 1'b1;
                in_gap = draw_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Backpressure on the constraint channel.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            out_stall = draw_gap();
        end
    end

    // Monitor: predicts on each accepted row, checks each accepted constraint.
    always @(posedge i_clk) begin
        t_ineq want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[odd_subset_constraint_generator] ERROR");
            $finish;
        end else if (i_rst_n) begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) expand_row(in_ch.row_index);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_ineqs.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected transaction, expected none, ",
                              "actual row_tag=%0d mask=%b bound=%0d last=%b"},
                             $time, out_ch.row_tag, out_ch.sign_mask, out_ch.bound,
                             out_ch.last);
                end else begin
                    want = expected_ineqs.pop_front();
                    check_field("row_tag", 16'(want.row_tag), 16'(out_ch.row_tag));
                    check_field("sign_mask", 16'(want.sign_mask), 16'(out_ch.sign_mask));
                    check_field("bound", 16'(want.bound), 16'(out_ch.bound));
                    check_field("last", 16'(want.last), 16'(out_ch.last));
                end
            end
        end else begin
            in_fire <= 1'b0;
        end
    end

    // Called on a falling edge; returns on a falling edge.
    task automatic write_reg(input logic [osc_pkg::PADDR_W-1:0] addr,
                             input logic [osc_pkg::PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == ADDR_ROW_DEGREE) shadow_degree = data[osc_pkg::DEG_W-1:0];
    endtask

    // The check runs after the driver's updates at the falling edge have settled.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_rows.size() != 0 || in_ch.valid || expected_ineqs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_rows(input int count);
        repeat (count) pending_rows.push_back(osc_pkg::ROW_W'($urandom_range(0, 1023)));
        wait_drained();
    endtask

    initial begin
        int rows_sent;
        int count;
        logic [osc_pkg::PDATA_W-1:0] word;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.row_index = '0;
        out_ch.ready    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset degree with the tag extremes and alternating bit patterns.
        pending_rows.push_back(osc_pkg::ROW_W'(0));
        pending_rows.push_back(osc_pkg::ROW_W'(1023));
        pending_rows.push_back(osc_pkg::ROW_W'(10'h155));
        pending_rows.push_back(osc_pkg::ROW_W'(10'h2AA));
        wait_drained();

        // Degree zero acts as one, seven saturates to six, odd degrees include the
        // full set.
        for (int deg = 0; deg < 8; deg++) begin
            write_reg(ADDR_ROW_DEGREE, osc_pkg::PDATA_W'(deg));
            run_rows(2);
        end
        // Upper data bits are dropped.
        write_reg(ADDR_ROW_DEGREE, 32'hFFFF_FFFA);
        run_rows(1);
        // A write to an unmapped register must leave the degree alone.
        write_reg(ADDR_UNMAPPED, 32'h0000_0005);
        run_rows(1);

        rows_sent = 0;
        while (rows_sent < RANDOM_ROWS) begin
            quiet_phase = ($urandom_range(3) == 0);
            if ($urandom_range(7) == 0) write_reg(ADDR_UNMAPPED, $urandom);
            word = $urandom;
            word[osc_pkg::DEG_W-1:0] = osc_pkg::DEG_W'($urandom_range(0, 7));
            write_reg(ADDR_ROW_DEGREE, word);
            count = $urandom_range(5, 25);
            run_rows(count);
            rows_sent += count;
        end

        if (errors == 0) begin
            $display("[odd_subset_constraint_generator] OK");
        end else begin
            $display("[odd_subset_constraint_generator] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/osc_pkg.sv
rtl/osc_if.sv
rtl/osc_ctrl.sv
rtl/osc_datapath.sv
rtl/odd_subset_constraint_generator.sv
rtl/osc_checker.sv
tb/tb.sv
